[hw/rtl/atmi_pkg.sv]
// Shared constants, codes and the command bundle for the allocation table.
package atmi_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam int KIND_W    = 2;
	localparam int TRAFFIC_W = 3;
	localparam int STATION_W = 12;
	localparam int ID_W      = 16;
	localparam int SLOT_W    = 16;
	localparam int COUNT_W   = 8;
	localparam int CHUNK_W   = 8;
	localparam int NEXT_W    = 9;
	localparam int USE_W     = 5;
	localparam int STATUS_W  = 2;
	localparam int TOTAL_W   = 20;

	localparam logic [KIND_W-1:0] KIND_ILLEGAL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NORMAL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RETX    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NEW    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_APPEND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLEAR  = 2'd3;

	localparam logic [ID_W-1:0]    ID_NONE   = 16'hFFFF;
	localparam logic [SLOT_W-1:0]  SLOT_MAX  = 16'hFFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

	// Register index (word address) on the configuration port
	localparam logic REG_ID_OFFSET = 1'b0;
	localparam logic REG_IN_USE    = 1'b1;

	// Command broadcast to every cell of the table
	typedef struct packed {
		logic                 clear;    // reset the entry
		logic                 apply;    // add item that is in range
		logic                 no_match; // no cell matched: write at chunk
		logic [CHUNK_W-1:0]   chunk;
		logic [KIND_W-1:0]    kind;
		logic [TRAFFIC_W-1:0] traffic;
		logic [ID_W-1:0]      id;
		logic [COUNT_W-1:0]   slots;
		logic [USE_W-1:0]     in_use;
	} cmd_t;

endpackage

[hw/rtl/alloc_table_merge_insert.sv]
// Allocation table with merge-on-insert: top level, control and configuration port.
//
// The table is a row of MAX_ENTRIES cells, each holding one entry (message kind,
// traffic kind, station id, slot count). An input transfer is registered, then in
// the apply state every cell compares itself with the item; a found flag ripples along
// the row so that only the lowest matching entry takes the slots, and when no cell
// matches the cell at the chunk index is overwritten. The retransmit and normal
// totals are built by a chain of registered adders that moves one cell per cycle,
// so each item goes from the input register through the apply state to the sum state,
// where the sequencer waits until the totals leave the chain and the output register
// is free; the next input transfer is taken only once the block is idle again. One
// item is in flight at a time; a finished result waits in the output register while
// the next item is taken. Registers: id_offset at byte address 0, entries_in_use at
// byte address 4; write them only while the block is idle.
module alloc_table_merge_insert import atmi_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [CHUNK_W-1:0]   chunk,
	input  logic [KIND_W-1:0]    msg_kind,
	input  logic [TRAFFIC_W-1:0] traffic_kind,
	input  logic [STATION_W-1:0] station,
	input  logic [COUNT_W-1:0]   slot_count,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [NEXT_W-1:0]    next_chunk,
	output logic [TOTAL_W-1:0]   retx_total,
	output logic [TOTAL_W-1:0]   normal_total
);

	localparam int SUM_W = SLOT_W + $clog2(MAX_ENTRIES + 1);
	localparam int EXT_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_APPLY = 2'd1;
	localparam logic [1:0] S_SUM   = 2'd2;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [STATION_W-1:0] id_offset_q;
	logic [USE_W-1:0]     in_use_q;

	logic                 action_q;
	logic [CHUNK_W-1:0]   chunk_q;
	logic [KIND_W-1:0]    kind_q;
	logic [TRAFFIC_W-1:0] traffic_q;
	logic [STATION_W-1:0] station_q;
	logic [COUNT_W-1:0]   slots_q;

	logic [STATUS_W-1:0]  res_status_q;
	logic [NEXT_W-1:0]    res_next_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [NEXT_W-1:0]    next_chunk_q;
	logic [TOTAL_W-1:0]   retx_total_q;
	logic [TOTAL_W-1:0]   normal_total_q;

	cmd_t                 cmd;
	logic                 reject;
	logic                 found_all;
	logic                 out_free;
	logic                 load_out;
	logic [ID_W-1:0]      item_id;
	logic [EXT_W-1:0]     retx_ext;
	logic [EXT_W-1:0]     norm_ext;

	logic                 found_w [0:MAX_ENTRIES];
	logic [SUM_W-1:0]     retx_w  [0:MAX_ENTRIES];
	logic [SUM_W-1:0]     norm_w  [0:MAX_ENTRIES];

	// Configuration port: word address picks the register, pready always high
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_offset_q <= '0;
			in_use_q    <= USE_W'(16);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ID_OFFSET: id_offset_q <= pwdata[STATION_W-1:0];
				REG_IN_USE:    in_use_q    <= pwdata[USE_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ID_OFFSET: prdata = 32'(id_offset_q);
			REG_IN_USE:    prdata = 32'(in_use_q);
			default:       prdata = '0;
		endcase
	end

	// Hold the accepted item for the apply cycle
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_q  <= action;
			chunk_q   <= chunk;
			kind_q    <= msg_kind;
			traffic_q <= traffic_kind;
			station_q <= station;
			slots_q   <= slot_count;
		end
	end

	// Station id after offset; the 13-bit sum never reaches the empty marker
	assign item_id = ID_W'({1'b0, station_q} + {1'b0, id_offset_q});

	// Chunk must lie below both the register and the table depth
	assign reject = ({1'b0, chunk_q} >= NEXT_W'(in_use_q))
		|| ({1'b0, chunk_q} >= NEXT_W'(MAX_ENTRIES));

	always_comb begin
		cmd.clear    = (state_q == S_APPLY) && action_q;
		cmd.apply    = (state_q == S_APPLY) && !action_q && !reject;
		cmd.no_match = !found_all;
		cmd.chunk    = chunk_q;
		cmd.kind     = kind_q;
		cmd.traffic  = traffic_q;
		cmd.id       = item_id;
		cmd.slots    = slots_q;
		cmd.in_use   = in_use_q;
	end

	// Row of cells: found flag ripples forward, partial totals advance per cycle
	assign found_w[0] = 1'b0;
	assign retx_w[0]  = '0;
	assign norm_w[0]  = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		atmi_cell #(
			.IDX   (i),
			.SUM_W (SUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.found_in  (found_w[i]),
			.found_out (found_w[i+1]),
			.retx_in   (retx_w[i]),
			.norm_in   (norm_w[i]),
			.retx_out  (retx_w[i+1]),
			.norm_out  (norm_w[i+1])
		);
	end

	assign found_all = found_w[MAX_ENTRIES];

	// Sequencer: apply the item, then wait for the totals to leave the row
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == S_SUM) && (cnt_q == CNT_W'(MAX_ENTRIES)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_SUM;
					cnt_q   <= '0;
				end
				S_SUM: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end else if (cnt_q != CNT_W'(MAX_ENTRIES)) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Status and next chunk are settled in the apply cycle
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			priority if (action_q) begin
				res_status_q <= ST_CLEAR;
				res_next_q   <= '0;
			end else if (reject) begin
				res_status_q <= ST_REJECT;
				res_next_q   <= '0;
			end else if (found_all) begin
				res_status_q <= ST_APPEND;
				res_next_q   <= NEXT_W'(chunk_q);
			end else begin
				res_status_q <= ST_NEW;
				res_next_q   <= NEXT_W'(chunk_q) + 1'b1;
			end
		end
	end

	// Saturate the totals taken from the end of the row
	assign retx_ext = EXT_W'(retx_w[MAX_ENTRIES]);
	assign norm_ext = EXT_W'(norm_w[MAX_ENTRIES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q       <= res_status_q;
			next_chunk_q   <= res_next_q;
			retx_total_q   <= (retx_ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX
				: retx_ext[TOTAL_W-1:0];
			normal_total_q <= (norm_ext > EXT_W'(TOTAL_MAX)) ? TOTAL_MAX
				: norm_ext[TOTAL_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign next_chunk   = next_chunk_q;
	assign retx_total   = retx_total_q;
	assign normal_total = normal_total_q;

endmodule

[hw/rtl/atmi_cell.sv]
// One table entry with its match link and running-total stage.
module atmi_cell import atmi_pkg::*; #(
	parameter int IDX   = 0,
	parameter int SUM_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic             found_in,
	output logic             found_out,
	input  logic [SUM_W-1:0] retx_in,
	input  logic [SUM_W-1:0] norm_in,
	output logic [SUM_W-1:0] retx_out,
	output logic [SUM_W-1:0] norm_out
);

	logic [KIND_W-1:0]    kind_q;
	logic [TRAFFIC_W-1:0] traffic_q;
	logic [ID_W-1:0]      id_q;
	logic [SLOT_W-1:0]    slots_q;
	logic [SUM_W-1:0]     retx_q;
	logic [SUM_W-1:0]     norm_q;

	logic              active;
	logic              match;
	logic              append;
	logic              write_new;
	logic [SLOT_W:0]   slot_sum;
	logic [SUM_W-1:0]  slots_ext;

	assign active    = {2'b00, cmd.in_use} > 7'(IDX);
	assign match     = active && (cmd.kind != KIND_ILLEGAL) && (id_q == cmd.id)
		&& (kind_q == cmd.kind);
	assign found_out = found_in | match;
	assign append    = cmd.apply && match && !found_in;
	assign write_new = cmd.apply && cmd.no_match && (cmd.chunk == CHUNK_W'(IDX));
	assign slot_sum  = {1'b0, slots_q} + (SLOT_W+1)'(cmd.slots);
	assign slots_ext = SUM_W'(slots_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= KIND_ILLEGAL;
			traffic_q <= '0;
			id_q      <= ID_NONE;
			slots_q   <= '0;
		end else if (cmd.clear) begin
			kind_q    <= KIND_ILLEGAL;
			traffic_q <= '0;
			id_q      <= ID_NONE;
			slots_q   <= '0;
		end else if (write_new) begin
			kind_q    <= cmd.kind;
			traffic_q <= cmd.traffic;
			id_q      <= cmd.id;
			slots_q   <= SLOT_W'(cmd.slots);
		end else if (append) begin
			slots_q <= slot_sum[SLOT_W] ? SLOT_MAX : slot_sum[SLOT_W-1:0];
		end
	end

	// Partial totals advance one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retx_q <= '0;
			norm_q <= '0;
		end else begin
			retx_q <= retx_in + ((active && kind_q == KIND_RETX) ? slots_ext : '0);
			norm_q <= norm_in + ((active && kind_q == KIND_NORMAL) ? slots_ext : '0);
		end
	end

	assign retx_out = retx_q;
	assign norm_out = norm_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the allocation table with merge-on-insert.
module tb;
	import atmi_pkg::*;

	// Operation codes on the action field, and the fourth message kind
	localparam logic            ACT_ADD    = 1'b0;
	localparam logic            ACT_CLEAR  = 1'b1;
	localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

	localparam int ITEMS_TARGET   = 1100;
	localparam int QUIET_ITEMS    = 100;   // closing stretch with no idling on either side
	localparam int HAMMER_ITEMS   = 270;   // enough 255-slot appends to saturate one entry
	localparam int SETTLE_CYCLES  = 40;    // settling time after the last result
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIR_N          = 22;
	localparam int IDX_W          = $clog2(MAX_ENTRIES_DEF);

	typedef struct packed {
		logic                 action;
		logic [CHUNK_W-1:0]   chunk;
		logic [KIND_W-1:0]    kind;
		logic [TRAFFIC_W-1:0] traffic;
		logic [STATION_W-1:0] station;
		logic [COUNT_W-1:0]   slots;
	} alloc_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NEXT_W-1:0]   next;
		logic [TOTAL_W-1:0]  retx;
		logic [TOTAL_W-1:0]  normal;
	} alloc_out_t;

	// One row of the directed table: optional register setting, the item, and
	// an outcome typed in by hand where it is obvious
	typedef struct packed {
		logic                 cfg_en;
		logic [STATION_W-1:0] cfg_off;
		logic [USE_W-1:0]     cfg_in_use;
		alloc_req_t           req;
		logic                 typed;
		alloc_out_t           res;
	} dir_row_t;

	// DUT connections
	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [2:0]           paddr        = '0;
	logic [31:0]          pwdata       = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic                 action       = ACT_ADD;
	logic [CHUNK_W-1:0]   chunk        = '0;
	logic [KIND_W-1:0]    msg_kind     = KIND_ILLEGAL;
	logic [TRAFFIC_W-1:0] traffic_kind = '0;
	logic [STATION_W-1:0] station      = '0;
	logic [COUNT_W-1:0]   slot_count   = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b1;
	logic [STATUS_W-1:0]  status;
	logic [NEXT_W-1:0]    next_chunk;
	logic [TOTAL_W-1:0]   retx_total;
	logic [TOTAL_W-1:0]   normal_total;

	alloc_table_merge_insert u_dut (.*);

	// Mirror of the table and its registers, kept by the predictor
	logic [KIND_W-1:0]    mirror_kind    [MAX_ENTRIES_DEF];
	logic [TRAFFIC_W-1:0] mirror_traffic [MAX_ENTRIES_DEF];
	logic [ID_W-1:0]      mirror_id      [MAX_ENTRIES_DEF];
	logic [SLOT_W-1:0]    mirror_slots   [MAX_ENTRIES_DEF];
	logic [STATION_W-1:0] mirror_offset = '0;
	logic [USE_W-1:0]     mirror_in_use = USE_W'(16);

	alloc_out_t predicted_outcomes [$];
	alloc_out_t want;
	int         mismatches  = 0;
	int         sent_count  = 0;
	int         idle_cycles = 0;
	int         ready_left  = 0;
	bit         quiet       = 1'b0;

	// Directed stimulus. Starts from reset state: offset 0, 16 entries in use.
	dir_row_t dir_tbl [DIR_N] = '{
		// after reset the table is empty: first add is a new entry
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd0, KIND_NORMAL, 3'd0, 12'd0, 8'd0},
			1'b1, '{ST_NEW, 9'd1, 20'd0, 20'd0}},
		'{1'b0, 12'd0, 5'd0, '{ACT_CLEAR, 8'd0, KIND_ILLEGAL, 3'd0, 12'd0, 8'd0},
			1'b1, '{ST_CLEAR, 9'd0, 20'd0, 20'd0}},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd0, KIND_NORMAL, 3'd7, 12'd0, 8'd255},
			1'b1, '{ST_NEW, 9'd1, 20'd0, 20'd255}},
		// same station and kind: merge into entry 0, chunk comes back unchanged
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd5, KIND_NORMAL, 3'd0, 12'd0, 8'd255},
			1'b1, '{ST_APPEND, 9'd5, 20'd0, 20'd510}},
		// chunk out of range
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd16, KIND_NORMAL, 3'd0, 12'd0, 8'd1},
			1'b1, '{ST_REJECT, 9'd0, 20'd0, 20'd510}},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd255, KIND_RETX, 3'd7, 12'd4095, 8'd255},
			1'b1, '{ST_REJECT, 9'd0, 20'd0, 20'd510}},
		// illegal kind never merges, even with an identical entry present
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd1, KIND_ILLEGAL, 3'd2, 12'd0, 8'd200},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd2, KIND_ILLEGAL, 3'd2, 12'd0, 8'd200},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd15, KIND_RETX, 3'd7, 12'd4095, 8'd255},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd3, KIND_OTHER, 3'd5, 12'd4095, 8'd255},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd4, KIND_RETX, 3'd1, 12'd4095, 8'd1},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd6, KIND_RETX, 3'd1, 12'd4095, 8'd7},
			1'b0, '0},
		// shrink the table: entry 15 is hidden, so a duplicate lands at 3
		'{1'b1, 12'd0, 5'd4, '{ACT_ADD, 8'd3, KIND_RETX, 3'd3, 12'd4095, 8'd9},
			1'b0, '0},
		// grow again: lowest of the two matches takes the slots
		'{1'b1, 12'd0, 5'd16, '{ACT_ADD, 8'd0, KIND_RETX, 3'd3, 12'd4095, 8'd2},
			1'b0, '0},
		// largest offset on top of the largest station
		'{1'b1, 12'd4095, 5'd16, '{ACT_ADD, 8'd7, KIND_NORMAL, 3'd4, 12'd4095, 8'd33},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd8, KIND_NORMAL, 3'd6, 12'd0, 8'd1},
			1'b0, '0},
		// no entries in use: every add rejected, totals zero
		'{1'b1, 12'd0, 5'd0, '{ACT_ADD, 8'd0, KIND_NORMAL, 3'd1, 12'd0, 8'd10},
			1'b1, '{ST_REJECT, 9'd0, 20'd0, 20'd0}},
		'{1'b0, 12'd0, 5'd0, '{ACT_CLEAR, 8'd255, KIND_OTHER, 3'd7, 12'd4095, 8'd255},
			1'b1, '{ST_CLEAR, 9'd0, 20'd0, 20'd0}},
		// in-use count above the table size acts as the table size
		'{1'b1, 12'd0, 5'd31, '{ACT_ADD, 8'd15, KIND_NORMAL, 3'd0, 12'd1, 8'd255},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd16, KIND_NORMAL, 3'd0, 12'd1, 8'd255},
			1'b1, '{ST_REJECT, 9'd0, 20'd0, 20'd255}},
		'{1'b1, 12'd0, 5'd1, '{ACT_ADD, 8'd0, KIND_OTHER, 3'd0, 12'd4095, 8'd128},
			1'b0, '0},
		'{1'b0, 12'd0, 5'd0, '{ACT_ADD, 8'd1, KIND_NORMAL, 3'd0, 12'd0, 8'd1},
			1'b0, '0}
	};

	always #2 clk = ~clk;

	function automatic int active_entries();
		return (int'(mirror_in_use) < MAX_ENTRIES_DEF) ? int'(mirror_in_use)
			: MAX_ENTRIES_DEF;
	endfunction

	function automatic void clear_mirror();
		for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
			mirror_kind[i]    = KIND_ILLEGAL;
			mirror_traffic[i] = '0;
			mirror_id[i]      = ID_NONE;
			mirror_slots[i]   = '0;
		end
	endfunction

	// Apply one item to the mirror and return the outcome it should produce
	function automatic alloc_out_t predict_alloc(alloc_req_t req);
		alloc_out_t o;
		int         n;
		int         sum;
		int         rsum;
		int         nsum;
		bit         found;
		logic [ID_W-1:0]  id;
		logic [IDX_W-1:0] wr_idx;
		n      = active_entries();
		o      = '0;
		rsum   = 0;
		nsum   = 0;
		found  = 1'b0;
		wr_idx = IDX_W'(req.chunk);
		if (req.action == ACT_CLEAR) begin
			clear_mirror();
			o.status = ST_CLEAR;
		end else if (int'(req.chunk) >= n) begin
			o.status = ST_REJECT;
		end else begin
			id = ID_W'(req.station) + ID_W'(mirror_offset);
			for (int i = 0; i < n && !found; i++) begin
				if (req.kind != KIND_ILLEGAL && mirror_id[i] == id
						&& mirror_kind[i] == req.kind) begin
					sum = int'(mirror_slots[i]) + int'(req.slots);
					mirror_slots[i] = (sum > int'(SLOT_MAX)) ? SLOT_MAX : SLOT_W'(sum);
					found = 1'b1;
				end
			end
			if (found) begin
				o.status = ST_APPEND;
				o.next   = NEXT_W'(req.chunk);
			end else begin
				mirror_kind[wr_idx]    = req.kind;
				mirror_traffic[wr_idx] = req.traffic;
				mirror_id[wr_idx]      = id;
				mirror_slots[wr_idx]   = SLOT_W'(req.slots);
				o.status = ST_NEW;
				o.next   = NEXT_W'(req.chunk) + NEXT_W'(1);
			end
		end
		for (int i = 0; i < n; i++) begin
			if (mirror_kind[i] == KIND_RETX)
				rsum += int'(mirror_slots[i]);
			if (mirror_kind[i] == KIND_NORMAL)
				nsum += int'(mirror_slots[i]);
		end
		o.retx   = (rsum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(rsum);
		o.normal = (nsum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(nsum);
		return o;
	endfunction

	// Hold off the sender until every predicted outcome has been seen
	task automatic drain_outcomes();
		@(negedge clk);
		in_valid = 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup, then access; the register takes the value on the access edge
	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_ID_OFFSET)
			mirror_offset = value[STATION_W-1:0];
		else
			mirror_in_use = value[USE_W-1:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Drain, then write both registers; stray upper data bits are ignored by the block
	task automatic set_config(input logic [STATION_W-1:0] off,
			input logic [USE_W-1:0] in_use_n);
		drain_outcomes();
		write_reg(REG_ID_OFFSET, (32'($urandom()) << STATION_W) | 32'(off));
		write_reg(REG_IN_USE, (32'($urandom()) << USE_W) | 32'(in_use_n));
	endtask

	// Offer one item, wait for its transfer, then log what it should produce
	task automatic send_item(input alloc_req_t req, input bit typed,
			input alloc_out_t typed_res, output alloc_out_t got);
		int         gap;
		alloc_out_t pred;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		if (gap != 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		action       = req.action;
		chunk        = req.chunk;
		msg_kind     = req.kind;
		traffic_kind = req.traffic;
		station      = req.station;
		slot_count   = req.slots;
		in_valid     = 1'b1;
		do @(posedge clk); while (!in_ready);
		pred = predict_alloc(req);
		predicted_outcomes.push_back(typed ? typed_res : pred);
		got = pred;
		sent_count++;
	endtask

	// Receiver: alternate bursts of ready and stall, held high in the closing stretch
	always @(negedge clk) begin
		if (quiet) begin
			out_ready = 1'b1;
		end else if (ready_left == 0) begin
			out_ready  = ($urandom_range(0, 3) != 0);
			ready_left = $urandom_range(1, 16);
		end else begin
			ready_left--;
		end
	end

	// Scoreboard: compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (predicted_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected result status=%0d next=%0d retx=%0d normal=%0d",
						status, next_chunk, retx_total, normal_total);
			end else begin
				want = predicted_outcomes.pop_front();
				if (status !== want.status || next_chunk !== want.next ||
						retx_total !== want.retx || normal_total !== want.normal) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"tb: mismatch exp status=%0d next=%0d retx=%0d normal=%0d,",
							" got status=%0d next=%0d retx=%0d normal=%0d"},
							want.status, want.next, want.retx, want.normal,
							status, next_chunk, retx_total, normal_total);
				end
			end
		end
	end

	// Watchdog: abort when no transfer happens on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		alloc_req_t           req;
		alloc_out_t           got;
		logic [STATION_W-1:0] pool [4];
		int                   cursor;
		int                   phase_len;
		int                   pick;
		logic [STATION_W-1:0] off;
		logic [USE_W-1:0]     in_use_n;

		clear_mirror();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: walk the table
		for (int i = 0; i < DIR_N; i++) begin
			if (dir_tbl[i].cfg_en)
				set_config(dir_tbl[i].cfg_off, dir_tbl[i].cfg_in_use);
			send_item(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].res, got);
		end

		// Saturation run: hammer one normal entry with full-size appends
		set_config(STATION_W'($urandom_range(0, 4095)), USE_W'(16));
		req = '{ACT_CLEAR, 8'd0, KIND_ILLEGAL, 3'd0, 12'd0, 8'd0};
		send_item(req, 1'b0, '0, got);
		req = '{ACT_ADD, 8'd0, KIND_NORMAL, TRAFFIC_W'($urandom_range(0, 7)),
			STATION_W'($urandom_range(0, 4095)), 8'd255};
		for (int i = 0; i < HAMMER_ITEMS; i++) begin
			req.chunk = CHUNK_W'($urandom_range(0, 15));
			send_item(req, 1'b0, '0, got);
		end

		// Random phases, each under its own register setting
		while (sent_count < ITEMS_TARGET) begin
			pick = $urandom_range(0, 2);
			off  = (pick == 0) ? STATION_W'(0) :
				(pick == 1) ? STATION_W'(4095) : STATION_W'($urandom_range(0, 4095));
			pick = $urandom_range(0, 9);
			case (pick)
				0: in_use_n = USE_W'(0);
				1: in_use_n = USE_W'(1);
				2: in_use_n = USE_W'(16);
				3: in_use_n = USE_W'(31);
				4: in_use_n = USE_W'($urandom_range(0, 31));
				default: in_use_n = USE_W'($urandom_range(2, 16));
			endcase
			set_config(off, in_use_n);
			pool[0] = '0;
			pool[1] = '1;
			pool[2] = STATION_W'($urandom_range(0, 4095));
			pool[3] = STATION_W'($urandom_range(0, 4095));
			cursor    = 0;
			phase_len = (in_use_n == 0) ? 10 : $urandom_range(30, 80);
			for (int i = 0; i < phase_len && sent_count < ITEMS_TARGET; i++) begin
				quiet = (sent_count >= ITEMS_TARGET - QUIET_ITEMS);
				// occasional full drain to leave the block idle mid-phase
				if (!quiet && $urandom_range(0, 99) == 0)
					drain_outcomes();
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					req = '{ACT_CLEAR, CHUNK_W'($urandom_range(0, 255)),
						KIND_W'($urandom_range(0, 3)),
						TRAFFIC_W'($urandom_range(0, 7)), STATION_W'($urandom_range(0, 4095)),
						COUNT_W'($urandom_range(0, 255))};
				end else if (pick < 14) begin
					// noise: any chunk, any station
					req = '{ACT_ADD, CHUNK_W'($urandom_range(0, 255)),
						KIND_W'($urandom_range(0, 3)),
						TRAFFIC_W'($urandom_range(0, 7)), STATION_W'($urandom_range(0, 4095)),
						COUNT_W'($urandom_range(0, 255))};
				end else begin
					// well-formed: fill the table in order from a small set of stations
					req.action  = ACT_ADD;
					req.chunk   = CHUNK_W'(cursor);
					req.kind    = ($urandom_range(0, 7) == 0) ? KIND_ILLEGAL
						: KIND_W'($urandom_range(1, 3));
					req.traffic = TRAFFIC_W'($urandom_range(0, 7));
					req.station = pool[2'($urandom_range(0, 3))];
					pick        = $urandom_range(0, 5);
					req.slots   = (pick == 0) ? COUNT_W'(0) :
						(pick == 1) ? COUNT_W'(255) : COUNT_W'($urandom_range(0, 255));
				end
				send_item(req, 1'b0, '0, got);
				if (got.status == ST_NEW)
					cursor = int'(got.next);
				if (got.status == ST_CLEAR || cursor >= active_entries())
					cursor = 0;
			end
		end

		// Drop valid, wait for the last results, then let the pipeline settle
		@(negedge clk);
		in_valid = 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
